>>> hw/rtl/lfu_replacement_table_assert.svh
// Assertion macros for the LFU replacement table, compiled out when ASSERT_OFF is set.
`ifndef LFU_REPLACEMENT_TABLE_ASSERT_SVH
`define LFU_REPLACEMENT_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

// Checks a condition at every clock edge outside reset.
`define LFU_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition at one edge implies another at the next edge.
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define LFU_ASSERT_ALWAYS(lbl, expr, msg)

`define LFU_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/lfu_pkg.sv
// Shared constants and types of the LFU replacement table.
`timescale 1ns / 1ps

package lfu_pkg;

  localparam int ENTRIES_DEF  = 5;
  localparam int KEY_BITS_DEF = 16;

  // Field widths of the request and result.
  localparam int REQ_KEY_W = 16;
  localparam int SLOT_W    = 3;
  localparam int COUNT_W   = 16;
  localparam int MISS_W    = 32;

  // Stream widths.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (SLOT_W + REQ_KEY_W + COUNT_W + MISS_W);
  localparam int OUT_TUSER_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [MISS_W-1:0]  MISS_MAX  = '1;

  // Replacement choice: the slot to fill and whether it already holds a key.
  typedef struct packed {
    logic              filled;
    logic [SLOT_W-1:0] slot;
  } victim_t;

endpackage

>>> hw/rtl/lfu_victim_sel.sv
// Least-frequently-used victim search over all slots.
`timescale 1ns / 1ps

module lfu_victim_sel #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
  input  logic [ENTRIES-1:0]                        slot_valid,
  input  logic [ENTRIES-1:0][lfu_pkg::COUNT_W-1:0]  slot_counts,
  output lfu_pkg::victim_t                          victim
);
  import lfu_pkg::*;

  logic [COUNT_W:0] rank [ENTRIES];
  logic [COUNT_W:0] best_rank;
  logic [SLOT_W-1:0] best_slot;
  logic             best_filled;

  // Empty slots rank zero, filled slots rank one above their use count.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank[i] = slot_valid[i] ? ({1'b0, slot_counts[i]} + 1'b1) : '0;
    end
  end

  // Linear minimum search; a strict compare keeps the lowest index on ties.
  always_comb begin
    best_rank   = rank[0];
    best_slot   = '0;
    best_filled = slot_valid[0];
    for (int i = 1; i < ENTRIES; i++) begin
      if (rank[i] < best_rank) begin
        best_rank   = rank[i];
        best_slot   = SLOT_W'(i);
        best_filled = slot_valid[i];
      end
    end
  end

  assign victim.filled = best_filled;
  assign victim.slot   = best_slot;

endmodule

>>> hw/rtl/lfu_replacement_table.sv
// Top level of the LFU replacement table: key match, replacement and result register.
//
//  Channel  Direction  Signals                      Contents
//  s        in         s_tvalid s_tready s_tdata    one key request
//  m        out        m_tvalid m_tready m_tdata    one lookup result per request
//                      m_tuser
//
// One request per cycle sustained while m_tready stays high; a request moves from
// the input register into the result register once the result register frees.
// The slot match and the minimum-count search are both done combinationally on
// that move, so a request sees the table as left by the request just before it.
// rst is synchronous: it empties every slot and clears the miss counter.
// A stalled result holds the result register; the input register drains into
// it as soon as it frees, so a request is taken in the same cycle the result leaves.
`timescale 1ns / 1ps
`include "lfu_replacement_table_assert.svh"

module lfu_replacement_table #(
  parameter int ENTRIES  = lfu_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lfu_pkg::KEY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lfu_pkg::IN_TDATA_W-1:0]    s_tdata,   // [15:0] request_key
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [2:0] slot_index, [18:3] evicted_key, [34:19] slot_use_count,
  // [66:35] miss_total, [71:67] zero
  output logic [lfu_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic [lfu_pkg::OUT_TUSER_W-1:0]   m_tuser    // [0] hit, [1] evicted_valid
);
  import lfu_pkg::*;

  // Input register.
  logic                in_valid;
  logic [KEY_BITS-1:0] in_key;

  // Table state.
  logic [KEY_BITS-1:0]              slot_keys [ENTRIES];
  logic [ENTRIES-1:0]               slot_valid;
  logic [ENTRIES-1:0][COUNT_W-1:0]  slot_counts;
  logic [MISS_W-1:0]                miss_counter;

  // Result register.
  logic                 out_valid;
  logic                 out_hit;
  logic [SLOT_W-1:0]    out_slot;
  logic                 out_ev_valid;
  logic [REQ_KEY_W-1:0] out_ev_key;
  logic [COUNT_W-1:0]   out_count;
  logic [MISS_W-1:0]    out_miss;

  // Datapath signals.
  logic                          advance;
  logic                          do_step;
  logic [KEY_BITS+REQ_KEY_W-1:0] key_ext;
  logic [ENTRIES-1:0]            hit_oh;
  logic                          hit_any;
  logic [SLOT_W-1:0]             hit_slot;
  logic [COUNT_W-1:0]            hit_count;
  logic [COUNT_W-1:0]            hit_count_next;
  victim_t                       victim;
  logic [ENTRIES-1:0]            vic_oh;
  logic [KEY_BITS-1:0]           vic_key;
  logic [KEY_BITS+REQ_KEY_W-1:0] ev_ext;
  logic [MISS_W-1:0]             miss_next;

  // Handshake: the result register frees when empty or taken.
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign do_step  = in_valid && advance;

  // Only the low KEY_BITS bits of the request take part.
  assign key_ext = {{KEY_BITS{1'b0}}, s_tdata[REQ_KEY_W-1:0]};

  // First valid slot holding the key.
  always_comb begin
    hit_oh    = '0;
    hit_any   = 1'b0;
    hit_slot  = '0;
    hit_count = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!hit_any && slot_valid[i] && (slot_keys[i] == in_key)) begin
        hit_any   = 1'b1;
        hit_oh[i] = 1'b1;
        hit_slot  = SLOT_W'(i);
        hit_count = slot_counts[i];
      end
    end
  end

  assign hit_count_next = (hit_count == COUNT_MAX) ? hit_count : hit_count + 1'b1;

  lfu_victim_sel #(
    .ENTRIES (ENTRIES)
  ) u_victim_sel (
    .slot_valid  (slot_valid),
    .slot_counts (slot_counts),
    .victim      (victim)
  );

  // Decode the victim and pick out the key it holds.
  always_comb begin
    vic_oh  = '0;
    vic_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (victim.slot == SLOT_W'(i)) begin
        vic_oh[i] = 1'b1;
        vic_key   = slot_keys[i];
      end
    end
  end

  assign ev_ext = {{REQ_KEY_W{1'b0}}, (victim.filled ? vic_key : {KEY_BITS{1'b0}})};

  // The miss counter saturates at its maximum.
  assign miss_next = (miss_counter == MISS_MAX) ? miss_counter : miss_counter + 1'b1;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
      slot_valid   <= '0;
      miss_counter <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (do_step && !hit_any) begin
        slot_valid   <= slot_valid | vic_oh;
        miss_counter <= miss_next;
      end
    end
  end

  // Input key capture.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_key <= key_ext[KEY_BITS-1:0];
    end
  end

  // Slot keys and use counts.
  always_ff @(posedge clk) begin
    if (do_step) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_any && hit_oh[i]) begin
          slot_counts[i] <= hit_count_next;
        end else if (!hit_any && vic_oh[i]) begin
          slot_keys[i]   <= in_key;
          slot_counts[i] <= '0;
        end
      end
    end
  end

  // Result register load.
  always_ff @(posedge clk) begin
    if (do_step) begin
      out_hit      <= hit_any;
      out_slot     <= hit_any ? hit_slot : victim.slot;
      out_ev_valid <= !hit_any && victim.filled;
      out_ev_key   <= hit_any ? '0 : ev_ext[REQ_KEY_W-1:0];
      out_count    <= hit_any ? hit_count_next : '0;
      out_miss     <= hit_any ? miss_counter : miss_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_miss, out_count, out_ev_key, out_slot};
  assign m_tuser  = {out_ev_valid, out_hit};

  // Consistency checks on results and table state.
  `LFU_ASSERT_ALWAYS(a_miss_count_zero, !(out_valid && !out_hit) || (out_count == '0), "miss result with nonzero use count")
  `LFU_ASSERT_ALWAYS(a_hit_no_evict, !(out_valid && out_hit) || !out_ev_valid, "hit result reports an eviction")
  `LFU_ASSERT_ALWAYS(a_slot_range, !out_valid || (32'(out_slot) < ENTRIES), "result slot beyond table")
  `LFU_ASSERT_NEXT(a_miss_monotonic, !rst, miss_counter >= $past(miss_counter), "miss counter decreased")
  `LFU_ASSERT_NEXT(a_valid_sticky, !rst, (slot_valid & $past(slot_valid)) == $past(slot_valid), "filled slot became empty")

endmodule
